// File: design/dtts_pkg.sv
// ----------------------------------------------------------------------------
// dtts_pkg
// Shared types and codes for the delayed task timer scheduler.
// ----------------------------------------------------------------------------
package dtts_pkg;

    localparam int DEF_NUM_SLOTS  = 16;
    localparam int DEF_FIFO_DEPTH = 16;

    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_SET      = 2'd1;
    localparam logic [1:0] CMD_DELETE   = 2'd2;
    localparam logic [1:0] CMD_DISPATCH = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  task_id;
        logic [15:0] start_delay;
        logic [15:0] repeat_period;
    } req_t;

    typedef struct packed {
        logic        dispatch_valid;
        logic [7:0]  dispatched_task;
        logic        set_failed;
        logic [4:0]  ready_level;
    } rsp_t;

    // one timer slot; task_id zero marks an empty slot
    typedef struct packed {
        logic [7:0]  task_id;
        logic [15:0] delay;
        logic [15:0] period;
    } slot_t;

endpackage

// File: design/dtts_slot_ram.sv
// ----------------------------------------------------------------------------
// dtts_slot_ram
// Timer slot memory: one write port, one registered read port. Per-entry
// valid bits make entries read as empty until first written after reset.
// ----------------------------------------------------------------------------
module dtts_slot_ram #(
    parameter int NUM_SLOTS = dtts_pkg::DEF_NUM_SLOTS,
    parameter int SW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            we,
    input  logic [SW-1:0]   waddr,
    input  dtts_pkg::slot_t wdata,
    input  logic [SW-1:0]   raddr,
    output dtts_pkg::slot_t rdata
);
    import dtts_pkg::*;

    slot_t                mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] vld_reg;
    slot_t                rd_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[raddr];
        end
    end

    assign rdata = rd_vld_reg ? rd_reg : '0;

endmodule

// File: design/delayed_task_timer_scheduler_core.sv
// ----------------------------------------------------------------------------
// delayed_task_timer_scheduler_core
// Software-style timer table with a ready queue of task ids.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_valid/req_ready, payload req) carries a command: tick,
//   set task, delete task or dispatch. Every request yields exactly one
//   response (rsp_valid/rsp_ready, payload rsp) in request order.
//   Requests are processed one at a time. A tick, set or delete walks the
//   slot RAM one slot per cycle with the read-modify-write pipelined; a set
//   then writes its chosen slot in a separate write state. A delete or a set
//   that hits an existing id ends the walk early, as does a tick that finds
//   the ready queue full. Set or delete with id zero and dispatch on an empty
//   queue go straight to the done state; a dispatch that pops passes through
//   a pop state first.
//   The response sits in an output register; the next request is accepted
//   while it waits. If the receiver stalls, the following request finishes
//   its work and holds in the done state until the output register frees.
//   Reset clears all slots (through per-slot valid bits, no clearing pass)
//   and empties the ready queue; the block accepts requests right after.
// ----------------------------------------------------------------------------
module delayed_task_timer_scheduler_core #(
    parameter int NUM_SLOTS  = dtts_pkg::DEF_NUM_SLOTS,
    parameter int FIFO_DEPTH = dtts_pkg::DEF_FIFO_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  dtts_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output dtts_pkg::rsp_t rsp
);
    import dtts_pkg::*;

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);
    localparam logic [PW-1:0] LAST_PTR  = PW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(FIFO_DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_SET_WR = 3'd2;
    localparam logic [2:0] S_POP    = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]    state_reg, state_next;
    req_t          req_reg, req_next;
    logic [SW-1:0] iss_reg, iss_next;
    logic          iss_done_reg, iss_done_next;
    logic [SW-1:0] proc_reg, proc_next;
    logic          pend_reg, pend_next;
    logic [SW-1:0] pick_reg, pick_next;
    logic          found_reg, found_next;
    logic          fail_reg, fail_next;
    logic          disp_reg, disp_next;
    logic [7:0]    task_reg, task_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg, rsp_next;

    logic          sw_we;
    logic [SW-1:0] sw_addr;
    slot_t         sw_data;
    slot_t         rd;
    logic          push;
    logic          finish;

    logic [7:0]    ready_fifo [FIFO_DEPTH];
    logic [7:0]    fifo_q;

    dtts_slot_ram #(
        .NUM_SLOTS (NUM_SLOTS),
        .SW        (SW)
    ) u_slot_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (sw_we),
        .waddr (sw_addr),
        .wdata (sw_data),
        .raddr (iss_reg),
        .rdata (rd)
    );

    // ready queue storage, head read registered every cycle
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ready_fifo[tail_reg] <= rd.task_id;
        end
        fifo_q <= ready_fifo[head_reg];
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        iss_next       = iss_reg;
        iss_done_next  = iss_done_reg;
        proc_next      = proc_reg;
        pend_next      = 1'b0;
        pick_next      = pick_reg;
        found_next     = found_reg;
        fail_next      = fail_reg;
        disp_next      = disp_reg;
        task_next      = task_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        sw_we          = 1'b0;
        sw_addr        = proc_reg;
        sw_data        = '0;
        push           = 1'b0;
        finish         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next      = req;
                    iss_next      = '0;
                    iss_done_next = 1'b0;
                    found_next    = 1'b0;
                    pick_next     = '0;
                    fail_next     = 1'b0;
                    disp_next     = 1'b0;
                    task_next     = '0;
                    if (req.command == CMD_DISPATCH)
                    begin
                        state_next = (count_reg == '0) ? S_DONE : S_POP;
                    end
                    else if (req.command != CMD_TICK && req.task_id == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // issue the next slot read while the previous one is processed
                if (!iss_done_reg)
                begin
                    pend_next = 1'b1;
                    proc_next = iss_reg;
                    if (iss_reg == LAST_SLOT)
                    begin
                        iss_done_next = 1'b1;
                    end
                    else
                    begin
                        iss_next = iss_reg + 1'b1;
                    end
                end

                if (pend_reg)
                begin
                    if (proc_reg == LAST_SLOT)
                    begin
                        finish = 1'b1;
                    end
                    case (req_reg.command)
                        CMD_TICK:
                        begin
                            if (rd.task_id != '0)
                            begin
                                if (rd.delay == '0)
                                begin
                                    if (count_reg == FULL_CNT)
                                    begin
                                        // queue full: leave this slot, end the walk
                                        finish = 1'b1;
                                    end
                                    else
                                    begin
                                        push       = 1'b1;
                                        count_next = count_reg + 1'b1;
                                        tail_next  = (tail_reg == LAST_PTR) ? '0
                                                                            : tail_reg + 1'b1;
                                        sw_we      = 1'b1;
                                        if (rd.period != '0)
                                        begin
                                            sw_data = '{task_id: rd.task_id,
                                                        delay:   rd.period,
                                                        period:  rd.period};
                                        end
                                    end
                                end
                                else
                                begin
                                    sw_we   = 1'b1;
                                    sw_data = '{task_id: rd.task_id,
                                                delay:   rd.delay - 16'd1,
                                                period:  rd.period};
                                end
                            end
                        end
                        CMD_SET:
                        begin
                            if (rd.task_id == req_reg.task_id)
                            begin
                                pick_next  = proc_reg;
                                found_next = 1'b1;
                                finish     = 1'b1;
                            end
                            else if (rd.task_id == '0 && !found_reg)
                            begin
                                pick_next  = proc_reg;
                                found_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            // delete: clear the first matching slot
                            if (rd.task_id == req_reg.task_id)
                            begin
                                sw_we  = 1'b1;
                                finish = 1'b1;
                            end
                        end
                    endcase
                end

                if (finish)
                begin
                    pend_next  = 1'b0;
                    state_next = (req_reg.command == CMD_SET) ? S_SET_WR : S_DONE;
                end
            end

            S_SET_WR:
            begin
                if (found_reg)
                begin
                    sw_we   = 1'b1;
                    sw_addr = pick_reg;
                    sw_data = '{task_id: req_reg.task_id,
                                delay:   req_reg.start_delay,
                                period:  req_reg.repeat_period};
                end
                else
                begin
                    fail_next = 1'b1;
                end
                state_next = S_DONE;
            end

            S_POP:
            begin
                disp_next  = 1'b1;
                task_next  = fifo_q;
                count_next = count_reg - 1'b1;
                head_next  = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_next.dispatch_valid  = disp_reg;
                    rsp_next.dispatched_task = task_reg;
                    rsp_next.set_failed      = fail_reg;
                    rsp_next.ready_level     = 5'(count_reg);
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iss_done_reg  <= 1'b0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            count_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_done_reg  <= iss_done_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        iss_reg  <= iss_next;
        proc_reg <= proc_next;
        pick_reg <= pick_next;
        fail_reg <= fail_next;
        disp_reg <= disp_next;
        task_reg <= task_next;
        rsp_reg  <= rsp_next;
    end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the delayed task timer scheduler against a cycle-free predictor of
// the slot table and ready queue. Directed cases cover ignored ids, empty
// dispatch, slot reuse, a full table and a full ready queue. Random traffic
// follows, with idle gaps and stalls on both channels. Output back-pressure
// and sender pauses are also exercised.
// ----------------------------------------------------------------------------
module testbench;
    import dtts_pkg::*;

    localparam int NUM_SLOTS    = DEF_NUM_SLOTS;
    localparam int FIFO_DEPTH   = DEF_FIFO_DEPTH;
    localparam int LIMIT_CYCLES = 1_000_000;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    // timer table and ready queue as the block should hold them
    logic [7:0]  tbl_id     [NUM_SLOTS] = '{default: '0};
    logic [15:0] tbl_delay  [NUM_SLOTS] = '{default: '0};
    logic [15:0] tbl_period [NUM_SLOTS] = '{default: '0};
    logic [7:0]  ready_q [$];

    rsp_t expected_rsp_q [$];
    int   sent_count     = 0;
    int   rsp_count      = 0;
    int   mismatch_count = 0;
    int   cycle_count    = 0;
    bit   tx_calm        = 1'b0;
    bit   rx_calm        = 1'b0;
    int   rx_hold_left   = 0;
    int   rx_stall_left  = 0;

    delayed_task_timer_scheduler_core #(
        .NUM_SLOTS  (NUM_SLOTS),
        .FIFO_DEPTH (FIFO_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic rsp_t schedule_predict(req_t r);
        rsp_t o;
        int   pick;
        o    = '0;
        pick = -1;
        case (r.command)
            CMD_TICK:
            begin
                for (int s = 0; s < NUM_SLOTS; s++)
                begin
                    if (tbl_id[s] != 8'd0)
                    begin
                        if (tbl_delay[s] == 16'd0)
                        begin
                            // stop the walk at the slot that cannot release
                            if (ready_q.size() >= FIFO_DEPTH)
                                break;
                            ready_q.push_back(tbl_id[s]);
                            if (tbl_period[s] != 16'd0)
                                tbl_delay[s] = tbl_period[s];
                            else
                            begin
                                tbl_id[s]     = '0;
                                tbl_delay[s]  = '0;
                                tbl_period[s] = '0;
                            end
                        end
                        else
                            tbl_delay[s] = tbl_delay[s] - 16'd1;
                    end
                end
            end
            CMD_SET:
            begin
                if (r.task_id != 8'd0)
                begin
                    // a slot already holding the id wins over an earlier empty one
                    for (int s = 0; s < NUM_SLOTS; s++)
                        if (pick < 0 && tbl_id[s] == r.task_id)
                            pick = s;
                    for (int s = 0; s < NUM_SLOTS; s++)
                        if (pick < 0 && tbl_id[s] == 8'd0)
                            pick = s;
                    if (pick < 0)
                        o.set_failed = 1'b1;
                    else
                    begin
                        tbl_id[pick]     = r.task_id;
                        tbl_delay[pick]  = r.start_delay;
                        tbl_period[pick] = r.repeat_period;
                    end
                end
            end
            CMD_DELETE:
            begin
                if (r.task_id != 8'd0)
                begin
                    for (int s = 0; s < NUM_SLOTS; s++)
                        if (pick < 0 && tbl_id[s] == r.task_id)
                            pick = s;
                    if (pick >= 0)
                    begin
                        tbl_id[pick]     = '0;
                        tbl_delay[pick]  = '0;
                        tbl_period[pick] = '0;
                    end
                end
            end
            default:
            begin
                if (ready_q.size() > 0)
                begin
                    o.dispatch_valid  = 1'b1;
                    o.dispatched_task = ready_q.pop_front();
                end
            end
        endcase
        o.ready_level = 5'(ready_q.size());
        return o;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && req_valid && req_ready)
            expected_rsp_q.push_back(schedule_predict(req));
    end

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            rsp_count++;
            if (expected_rsp_q.size() == 0)
            begin
                $error("response with no request pending: %p", rsp);
                mismatch_count++;
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                check_field("dispatch_valid", want.dispatch_valid, rsp.dispatch_valid);
                check_field("dispatched_task", want.dispatched_task, rsp.dispatched_task);
                check_field("set_failed", want.set_failed, rsp.set_failed);
                check_field("ready_level", want.ready_level, rsp.ready_level);
            end
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len(bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 65)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            rsp_ready <= 1'b0;
            rx_hold_left--;
        end
        else if (rx_stall_left > 0)
        begin
            rsp_ready <= 1'b0;
            rx_stall_left--;
        end
        else if (!rx_calm && $urandom_range(0, 99) < 25)
        begin
            rsp_ready     <= 1'b0;
            rx_stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                         : $urandom_range(8, 40);
        end
        else
            rsp_ready <= 1'b1;
    end

    function automatic req_t mk_req(logic [1:0] c, logic [7:0] id,
                                    logic [15:0] d, logic [15:0] p);
        req_t r;
        r.command       = c;
        r.task_id       = id;
        r.start_delay   = d;
        r.repeat_period = p;
        return r;
    endfunction

    // offer one request, hold it until accepted, then maybe idle a while
    task automatic send_req(req_t r);
        int gap;
        gap = idle_len(tx_calm);
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (!req_ready);
        sent_count++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // drop valid and hold off until every response is back
    task automatic wait_drained();
        req_valid <= 1'b0;
        do @(posedge clk); while (rsp_count < sent_count);
    endtask

    function automatic req_t rand_req(int wt, int ws, int wd, int wp);
        req_t r;
        int   roll;
        roll = $urandom_range(0, wt + ws + wd + wp - 1);
        if (roll < wt)
            r.command = CMD_TICK;
        else if (roll < wt + ws)
            r.command = CMD_SET;
        else if (roll < wt + ws + wd)
            r.command = CMD_DELETE;
        else
            r.command = CMD_DISPATCH;
        roll = $urandom_range(0, 99);
        r.task_id = (roll < 85) ? 8'($urandom_range(1, 24))
                  : (roll < 96) ? 8'($urandom_range(0, 255)) : 8'd0;
        roll = $urandom_range(0, 99);
        r.start_delay = (roll < 70) ? 16'($urandom_range(0, 3))
                      : (roll < 90) ? 16'($urandom_range(4, 40))
                                    : 16'($urandom_range(0, 65535));
        roll = $urandom_range(0, 99);
        r.repeat_period = (roll < 40) ? 16'd0
                        : (roll < 80) ? 16'($urandom_range(1, 4))
                        : (roll < 95) ? 16'($urandom_range(5, 40))
                                      : 16'($urandom_range(0, 65535));
        return r;
    endfunction

    task automatic run_traffic(int n, int wt, int ws, int wd, int wp);
        repeat (n) send_req(rand_req(wt, ws, wd, wp));
    endtask

    task automatic test_directed_cases();
        send_req(mk_req(CMD_DISPATCH, 8'd0, 16'd0, 16'd0));
        send_req(mk_req(CMD_SET, 8'd0, 16'hFFFF, 16'hFFFF));
        send_req(mk_req(CMD_DELETE, 8'd0, 16'd0, 16'd0));
        send_req(mk_req(CMD_DELETE, 8'd77, 16'd0, 16'd0));
        send_req(mk_req(CMD_SET, 8'd255, 16'hFFFF, 16'hFFFF));
        send_req(mk_req(CMD_SET, 8'd1, 16'd0, 16'd0));
        send_req(mk_req(CMD_SET, 8'd2, 16'd1, 16'd2));
        send_req(mk_req(CMD_TICK, 8'd0, 16'd0, 16'd0));
        send_req(mk_req(CMD_TICK, 8'hFF, 16'hFFFF, 16'hFFFF));
        send_req(mk_req(CMD_DISPATCH, 8'd0, 16'd0, 16'd0));
        send_req(mk_req(CMD_DISPATCH, 8'd0, 16'd0, 16'd0));
        send_req(mk_req(CMD_DISPATCH, 8'd0, 16'd0, 16'd0));
        send_req(mk_req(CMD_DELETE, 8'd255, 16'd0, 16'd0));
        // id 2 sits behind two empty slots and must stay in place
        send_req(mk_req(CMD_SET, 8'd2, 16'd0, 16'd0));
        send_req(mk_req(CMD_SET, 8'd3, 16'd0, 16'd1));
        send_req(mk_req(CMD_TICK, 8'd0, 16'd0, 16'd0));
        send_req(mk_req(CMD_DELETE, 8'd3, 16'd0, 16'd0));
        send_req(mk_req(CMD_DISPATCH, 8'd0, 16'd0, 16'd0));
        send_req(mk_req(CMD_DISPATCH, 8'd0, 16'd0, 16'd0));
    endtask

    task automatic test_table_full();
        logic [7:0] live [$];
        int         base;
        int         backlog;
        wait_drained();
        foreach (tbl_id[s])
            if (tbl_id[s] != 8'd0)
                live.push_back(tbl_id[s]);
        backlog = ready_q.size();
        foreach (live[i])
            send_req(mk_req(CMD_DELETE, live[i], 16'd0, 16'd0));
        repeat (backlog) send_req(mk_req(CMD_DISPATCH, 8'd0, 16'd0, 16'd0));
        base = $urandom_range(1, 239);
        for (int s = 0; s < NUM_SLOTS; s++)
            send_req(mk_req(CMD_SET, 8'(base + s), 16'd0, 16'd1));
        send_req(mk_req(CMD_SET, 8'(base + NUM_SLOTS), 16'd5, 16'd5));
        send_req(mk_req(CMD_SET, 8'(base + 5), 16'd0, 16'd1));
        // third tick meets a full ready queue at the first slot
        repeat (3) send_req(mk_req(CMD_TICK, 8'd0, 16'd0, 16'd0));
        repeat (FIFO_DEPTH + 1) send_req(mk_req(CMD_DISPATCH, 8'd0, 16'd0, 16'd0));
        send_req(mk_req(CMD_TICK, 8'd0, 16'd0, 16'd0));
        for (int s = 0; s < NUM_SLOTS; s++)
            send_req(mk_req(CMD_DELETE, 8'(base + s), 16'd0, 16'd0));
    endtask

    task automatic test_mixed_traffic();
        run_traffic(600, 30, 35, 10, 25);
    endtask

    task automatic test_ready_overflow();
        run_traffic(350, 45, 40, 5, 10);
    endtask

    task automatic test_dispatch_drain();
        run_traffic(300, 25, 20, 15, 40);
    endtask

    task automatic test_back_to_back();
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        run_traffic(300, 35, 30, 10, 25);
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    task automatic test_output_backpressure();
        tx_calm      = 1'b1;
        rx_hold_left = 400;
        run_traffic(24, 30, 40, 10, 20);
        tx_calm = 1'b0;
    endtask

    task automatic test_sender_pause();
        run_traffic(100, 30, 35, 10, 25);
        wait_drained();
        run_traffic(100, 30, 35, 10, 25);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        rsp_ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_table_full();
        test_mixed_traffic();
        test_ready_overflow();
        test_output_backpressure();
        test_dispatch_drain();
        test_back_to_back();
        test_sender_pause();
        wait_drained();
        repeat (NUM_SLOTS + 8) @(posedge clk);
        if (expected_rsp_q.size() != 0)
        begin
            $error("%0d responses never arrived", expected_rsp_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
design/dtts_pkg.sv
design/dtts_slot_ram.sv
design/delayed_task_timer_scheduler_core.sv
verif/testbench.sv
